/* hw/rtl/ates_pkg.sv */
// ----------------------------------------------------------------------------
// ates_pkg
// Shared types and constants for the table edit and sort engine.
// ----------------------------------------------------------------------------
package ates_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int MAX_OUT  = 64;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_DELETE  = 3'd1;
    localparam logic [2:0] ACT_DUMP    = 3'd2;
    localparam logic [2:0] ACT_REVERSE = 3'd3;
    localparam logic [2:0] ACT_SORT    = 3'd4;
    localparam logic [2:0] ACT_ROTATE  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_POS = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         position;
        logic signed [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] element;
        logic [5:0]         element_position;
        logic [6:0]         fill_count;
        logic               last;
    } t_out_item;

endpackage

/* hw/rtl/ates_ram.sv */
// ----------------------------------------------------------------------------
// ates_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ates_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* hw/rtl/array_table_edit_sort_engine.sv */
// ----------------------------------------------------------------------------
// array_table_edit_sort_engine
// Table of signed 32-bit entries with insert, delete, dump, reverse,
// bubble sort and rotate-right actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one action item. The block takes
//   one item at a time; o_stall stays high while an item is in work.
//   Output channel o_valid/i_stall carries result items. Each action except
//   dump gives one status item; dump gives one item per entry (at most 64),
//   or one empty status item, with last set on the final one.
//   The table lives in one single-port RAM (one access per cycle, read
//   data registered). Insert and delete shift the entries from the
//   position up, rotate shifts every entry, reverse swaps pairs from both
//   ends, sort runs bubble passes whose work grows quadratically with the
//   count, and dump reads one entry per result item.
//   Each result is loaded into the output register once that register is free.
//   Reset clears the fill count and control; table contents are undefined
//   until written and never read above the fill count.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module array_table_edit_sort_engine
    import ates_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    typedef enum logic [4:0] {
        S_IDLE, S_RESP,
        S_WK_RD, S_WK_WR, S_PRE, S_PCAP,
        S_DL_RD, S_DL_WR,
        S_RV_A, S_RV_B, S_RV_C, S_RV_D,
        S_SO_FIRST, S_SO_LOAD, S_SO_RD, S_SO_CMP, S_SO_END,
        S_DU_RD, S_DU_OUT
    } t_state;

    t_state          r_state;
    logic            r_ins;    // walk belongs to an insert
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_i;      // main index
    logic [CW-1:0]   r_j;      // end index / second index / pass limit
    logic [31:0]     r_a;      // carried entry
    logic [2:0]      r_status;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [31:0]     ram_wdata;
    logic [31:0]     ram_rdata;

    ates_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic          out_free;
    logic          out_load;
    logic          sort_lt;
    logic [CW-1:0] last_idx;
    logic [CW-1:0] dump_n;

    assign out_free = !o_valid || !i_stall;
    assign out_load = out_free && (r_state == S_RESP || r_state == S_DU_OUT);
    assign o_stall  = (r_state != S_IDLE);
    assign sort_lt  = $signed(ram_rdata) < $signed(r_a);
    assign last_idx = r_count - CW'(1);
    assign dump_n   = (r_count > CW'(MAX_OUT)) ? CW'(MAX_OUT) : r_count;

    // Memory port: one access a cycle, chosen by the sequencer.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_i[AW-1:0];
        ram_wdata = r_a;
        unique case (r_state)
            S_WK_WR: begin
                ram_we = 1'b1;
            end
            S_PRE: begin
                ram_addr = last_idx[AW-1:0];
            end
            S_DL_RD: begin
                ram_addr = AW'(r_i + CW'(1));
            end
            S_DL_WR, S_RV_C: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_RV_B: begin
                ram_addr = r_j[AW-1:0];
            end
            S_RV_D, S_SO_END: begin
                ram_we   = 1'b1;
                ram_addr = r_j[AW-1:0];
            end
            S_SO_FIRST: begin
                ram_addr = '0;
            end
            S_SO_CMP: begin
                // smaller entry drops into the lower slot
                ram_we    = 1'b1;
                ram_addr  = AW'(r_i - CW'(1));
                ram_wdata = sort_lt ? ram_rdata : r_a;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            // Output register: load a result when free, drop it once taken.
            if (out_load) begin
                o_valid <= 1'b1;
                if (r_state == S_DU_OUT) begin
                    o_item.status           <= ST_OK;
                    o_item.element          <= ram_rdata;
                    o_item.element_position <= 6'(r_i);
                    o_item.last             <= (r_i + CW'(1) == dump_n);
                end else begin
                    o_item.status           <= r_status;
                    o_item.element          <= '0;
                    o_item.element_position <= '0;
                    o_item.last             <= 1'b1;
                end
                o_item.fill_count <= 7'(r_count);
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_status <= ST_OK;
                        r_ins    <= (i_item.action == ACT_INSERT);
                        r_state  <= S_RESP;
                        unique case (i_item.action)
                            ACT_INSERT: begin
                                if (CW'(i_item.position) > r_count)
                                    r_status <= ST_BAD_POS;
                                else if (r_count >= CW'(CAPACITY))
                                    r_status <= ST_FULL;
                                else begin
                                    // walk up from pos carrying the new value
                                    r_a     <= i_item.entry_value;
                                    r_i     <= CW'(i_item.position);
                                    r_j     <= r_count;
                                    r_state <= (CW'(i_item.position) == r_count)
                                               ? S_WK_WR : S_WK_RD;
                                end
                            end
                            ACT_DELETE: begin
                                if (r_count == '0)
                                    r_status <= ST_EMPTY;
                                else if (CW'(i_item.position) >= r_count)
                                    r_status <= ST_BAD_POS;
                                else if (CW'(i_item.position) + CW'(1) == r_count)
                                    r_count <= r_count - CW'(1);
                                else begin
                                    r_i     <= CW'(i_item.position);
                                    r_state <= S_DL_RD;
                                end
                            end
                            ACT_DUMP: begin
                                if (r_count == '0)
                                    r_status <= ST_EMPTY;
                                else begin
                                    r_i     <= '0;
                                    r_state <= S_DU_RD;
                                end
                            end
                            ACT_REVERSE: begin
                                if (r_count > CW'(1)) begin
                                    r_i     <= '0;
                                    r_j     <= last_idx;
                                    r_state <= S_RV_A;
                                end
                            end
                            ACT_SORT: begin
                                if (r_count > CW'(1)) begin
                                    r_i     <= CW'(1);
                                    r_j     <= last_idx;  // pass limit
                                    r_state <= S_SO_FIRST;
                                end
                            end
                            ACT_ROTATE: begin
                                if (r_count == '0)
                                    r_status <= ST_EMPTY;
                                else if (r_count > CW'(1)) begin
                                    r_i     <= '0;
                                    r_j     <= last_idx;
                                    r_state <= S_PRE; // fetch last entry first
                                end
                            end
                            default: r_status <= ST_UNKNOWN;
                        endcase
                    end
                end
                // Shift up: write the carried entry, carry the old one on.
                S_WK_RD: r_state <= S_WK_WR;
                S_WK_WR: begin
                    r_a <= ram_rdata;
                    if (r_i == r_j) begin
                        if (r_ins)
                            r_count <= r_count + CW'(1);
                        r_state <= S_RESP;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= (r_i + CW'(1) == r_j) ? S_WK_WR : S_WK_RD;
                    end
                end
                S_PRE: r_state <= S_PCAP;
                S_PCAP: begin
                    r_a     <= ram_rdata;
                    r_state <= S_WK_RD;
                end
                // Shift down: entry i+1 moves into slot i.
                S_DL_RD: r_state <= S_DL_WR;
                S_DL_WR: begin
                    if (r_i + CW'(2) == r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_RESP;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_DL_RD;
                    end
                end
                // Reverse: swap the pair at i and j, then close in.
                S_RV_A: r_state <= S_RV_B;
                S_RV_B: begin
                    r_a     <= ram_rdata;
                    r_state <= S_RV_C;
                end
                S_RV_C: r_state <= S_RV_D;
                S_RV_D: begin
                    if (r_i + CW'(2) < r_j) begin
                        r_i     <= r_i + CW'(1);
                        r_j     <= r_j - CW'(1);
                        r_state <= S_RV_A;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                // Sort: each pass carries the largest entry up to the limit.
                S_SO_FIRST: r_state <= S_SO_LOAD;
                S_SO_LOAD: begin
                    r_a     <= ram_rdata;
                    r_state <= S_SO_CMP;
                end
                S_SO_RD: r_state <= S_SO_CMP;
                S_SO_CMP: begin
                    if (!sort_lt)
                        r_a <= ram_rdata;
                    if (r_i == r_j) begin
                        r_state <= S_SO_END;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SO_RD;
                    end
                end
                S_SO_END: begin
                    if (r_j == CW'(1)) begin
                        r_state <= S_RESP;
                    end else begin
                        r_j     <= r_j - CW'(1);
                        r_i     <= CW'(1);
                        r_state <= S_SO_FIRST;
                    end
                end
                // Dump: read data holds while the address holds.
                S_DU_RD: r_state <= S_DU_OUT;
                S_DU_OUT: begin
                    if (out_free) begin
                        if (r_i + CW'(1) == dump_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_DU_RD;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Handshake sanity on the block's own sequencing.
    ast_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accepted item while busy");
    ast_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");
    ast_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");
    ast_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_item))
        else $error("result changed while stalled");

endmodule
